// File: sv/fbfc_pkg.sv
// ----------------------------------------------------------------------------
// fbfc_pkg: shared types and constants of the free bitmap search block
// Sizes of the bitmap, word layout, operation codes and sequencer states.
// ----------------------------------------------------------------------------
package fbfc_pkg;

	localparam int BITS      = 8192;
	localparam int WORD_BITS = 32;
	localparam int WORDS     = (BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W    = $clog2(WORDS);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int POS_W     = 13;
	localparam int OP_W      = 3;

	typedef enum logic [OP_W-1:0] {
		OP_FIND  = 3'd0,
		OP_SET   = 3'd1,
		OP_CLEAR = 3'd2,
		OP_TEST  = 3'd3,
		OP_FLIP  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BITOP,
		ST_SRCH,
		ST_DONE
	} state_t;

endpackage

// File: sv/fbfc_scan.sv
// ----------------------------------------------------------------------------
// fbfc_scan: lowest clear bit of one bitmap word
// Masks off bits outside the search window and encodes the lowest clear bit.
// ----------------------------------------------------------------------------
module fbfc_scan (
	input  logic [fbfc_pkg::WORD_BITS-1:0] word,
	input  logic [fbfc_pkg::BIT_W-1:0]     lo,
	input  logic [fbfc_pkg::BIT_W-1:0]     hi,
	input  logic                           first,
	input  logic                           last,
	output logic                           hit,
	output logic [fbfc_pkg::BIT_W-1:0]     enc
);

	logic [fbfc_pkg::WORD_BITS-1:0] clr;

	always_comb begin
		for (int i = 0; i < fbfc_pkg::WORD_BITS; i++) begin
			clr[i] = !word[i]
				&& (!first || (fbfc_pkg::BIT_W'(i) >= lo))
				&& (!last || (fbfc_pkg::BIT_W'(i) <= hi));
		end
	end

	// highest index first so the lowest clear bit wins
	always_comb begin
		enc = '0;
		for (int i = fbfc_pkg::WORD_BITS - 1; i >= 0; i--) begin
			if (clr[i]) begin
				enc = fbfc_pkg::BIT_W'(i);
			end
		end
	end

	assign hit = |clr;

endmodule

// File: sv/free_bitmap_first_clear_search.sv
// ----------------------------------------------------------------------------
// free_bitmap_first_clear_search: free-block bitmap with first-clear search
// Holds the bitmap in one word-wide RAM; serves set, clear, test, flip and
// a lowest-clear-bit search over an inclusive position range.
// ----------------------------------------------------------------------------
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | op, bit_index, range_start, range_end
//  out     | out_valid/out_stall | found, position, bit_value, bad_request
//
//  Set, clear, test and flip go through RAM read, read-modify-write and
//  result hand-off. A search reads one RAM word per cycle over the words
//  the range touches up to the hit (1..256), then hands off its result.
//  Reversed, out-of-range and unused requests go straight to hand-off.
//  Reset clears a flip-flop valid bit per word; an unwritten word reads as
//  zero, so the bitmap is free at once after reset with no clearing pass.
//  A stalled result waits in the output register while the next request is
//  taken; only the final hand-off of that next request waits on it.
//
module free_bitmap_first_clear_search (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fbfc_pkg::OP_W-1:0]   op,
	input  logic [fbfc_pkg::POS_W-1:0]  bit_index,
	input  logic [fbfc_pkg::POS_W-1:0]  range_start,
	input  logic [fbfc_pkg::POS_W-1:0]  range_end,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [fbfc_pkg::POS_W-1:0]  position,
	output logic                        bit_value,
	output logic                        bad_request
);

	localparam int AW = fbfc_pkg::ADDR_W;
	localparam int BW = fbfc_pkg::BIT_W;
	localparam int DW = fbfc_pkg::WORD_BITS;
	localparam int PW = fbfc_pkg::POS_W;

	// bitmap RAM and its per-word valid bits
	logic [DW-1:0]                mem [fbfc_pkg::WORDS];
	logic [fbfc_pkg::WORDS-1:0]   vld_q;
	logic [DW-1:0]                rdata_q;
	logic                         rvld_q;
	logic [AW-1:0]                raddr;
	logic                         we;
	logic [DW-1:0]                wdata;

	// sequencer
	fbfc_pkg::state_t state_q, state_d;
	fbfc_pkg::op_t    op_q;
	logic [PW-1:0]    idx_q;
	logic [PW-1:0]    rs_q;
	logic [PW-1:0]    re_q;
	logic [AW-1:0]    wa_q, wa_d;
	logic             accept;

	// pending result, loaded into the output register in the DONE state
	logic             res_ld;
	logic             res_found_d, res_val_d, res_bad_d;
	logic [PW-1:0]    res_pos_d;
	logic             res_found_q, res_val_q, res_bad_q;
	logic [PW-1:0]    res_pos_q;

	logic             out_ld;
	logic             out_valid_q;

	// search helpers
	logic [DW-1:0]    word;
	logic             scan_hit;
	logic [BW-1:0]    scan_enc;
	logic             at_first, at_last;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != fbfc_pkg::ST_IDLE);
	assign word     = rvld_q ? rdata_q : '0;
	assign at_first = (wa_q == rs_q[BW +: AW]);
	assign at_last  = (wa_q == re_q[BW +: AW]);

	fbfc_scan u_scan (
		.word  (word),
		.lo    (rs_q[BW-1:0]),
		.hi    (re_q[BW-1:0]),
		.first (at_first),
		.last  (at_last),
		.hit   (scan_hit),
		.enc   (scan_enc)
	);

	// next state, RAM access and result
	always_comb begin
		logic [DW-1:0] m;
		logic          idx_ok;
		logic          cur;
		state_d     = state_q;
		wa_d        = wa_q;
		raddr       = wa_q + AW'(1);
		we          = 1'b0;
		wdata       = word;
		res_ld      = 1'b0;
		res_found_d = 1'b0;
		res_pos_d   = '0;
		res_val_d   = 1'b0;
		res_bad_d   = 1'b0;
		out_ld      = 1'b0;
		m           = DW'(1) << idx_q[BW-1:0];
		idx_ok      = (32'(idx_q) < fbfc_pkg::BITS);
		cur         = word[idx_q[BW-1:0]];
		case (state_q)
			fbfc_pkg::ST_IDLE: begin
				// read the first word the request needs as it is taken
				if (op == fbfc_pkg::OP_FIND) begin
					raddr = range_start[BW +: AW];
				end else begin
					raddr = bit_index[BW +: AW];
				end
				if (accept) begin
					wa_d   = raddr;
					res_ld = 1'b1;
					case (op)
						fbfc_pkg::OP_FIND: begin
							if (range_start > range_end) begin
								res_bad_d = 1'b1;
								state_d   = fbfc_pkg::ST_DONE;
							end else if ((32'(range_start) < fbfc_pkg::BITS)
									&& (32'(range_end) < fbfc_pkg::BITS)) begin
								state_d = fbfc_pkg::ST_SRCH;
							end else begin
								state_d = fbfc_pkg::ST_DONE;
							end
						end
						fbfc_pkg::OP_SET, fbfc_pkg::OP_CLEAR,
						fbfc_pkg::OP_TEST, fbfc_pkg::OP_FLIP: begin
							state_d = fbfc_pkg::ST_BITOP;
						end
						default: begin
							state_d = fbfc_pkg::ST_DONE;
						end
					endcase
				end
			end
			fbfc_pkg::ST_BITOP: begin
				// modify the fetched word and write it back (test only reads it)
				res_ld  = 1'b1;
				state_d = fbfc_pkg::ST_DONE;
				case (op_q)
					fbfc_pkg::OP_SET: begin
						we    = idx_ok;
						wdata = word | m;
					end
					fbfc_pkg::OP_CLEAR: begin
						we    = idx_ok;
						wdata = word & ~m;
					end
					fbfc_pkg::OP_FLIP: begin
						we        = idx_ok;
						wdata     = word ^ m;
						res_val_d = idx_ok && !cur;
					end
					fbfc_pkg::OP_TEST: begin
						res_val_d = idx_ok && cur;
					end
					default: begin
					end
				endcase
			end
			fbfc_pkg::ST_SRCH: begin
				// one word per cycle; the next word is read speculatively
				if (scan_hit) begin
					res_ld      = 1'b1;
					res_found_d = 1'b1;
					res_pos_d   = PW'({wa_q, scan_enc});
					state_d     = fbfc_pkg::ST_DONE;
				end else if (at_last) begin
					res_ld  = 1'b1;
					state_d = fbfc_pkg::ST_DONE;
				end else begin
					wa_d = wa_q + AW'(1);
				end
			end
			fbfc_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_ld  = 1'b1;
					state_d = fbfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fbfc_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fbfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request fields, word pointer and pending result
	always_ff @(posedge clk) begin
		wa_q <= wa_d;
		if (accept) begin
			op_q  <= fbfc_pkg::op_t'(op);
			idx_q <= bit_index;
			rs_q  <= range_start;
			re_q  <= range_end;
		end
		if (res_ld) begin
			res_found_q <= res_found_d;
			res_pos_q   <= res_pos_d;
			res_val_q   <= res_val_d;
			res_bad_q   <= res_bad_d;
		end
	end

	// RAM: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa_q] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	// valid bits: an unwritten word reads as all clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[wa_q] <= 1'b1;
			end
			rvld_q <= vld_q[raddr];
		end
	end

	// output register: drop on transfer, load from the pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			found       <= res_found_q;
			position    <= res_pos_q;
			bit_value   <= res_val_q;
			bad_request <= res_bad_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_write_only_in_bitop: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == fbfc_pkg::ST_BITOP))
		else $error("bitmap write outside read-modify-write");

	a_scan_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == fbfc_pkg::ST_SRCH) |->
		((wa_q >= rs_q[BW +: AW]) && (wa_q <= re_q[BW +: AW])))
		else $error("search pointer left the range");

	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == fbfc_pkg::ST_DONE) && res_found_q) |->
		((res_pos_q >= rs_q) && (res_pos_q <= re_q)))
		else $error("search hit outside the requested range");

	a_found_not_bad: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(found && bad_request))
		else $error("result both found and bad");
`endif

endmodule
